### rtl/core/scsd_pkg.sv
`timescale 1ns / 1ps

package scsd_pkg;

    // Display geometry.
    localparam int DIGIT_COUNT = 6;
    localparam int DIGIT_IDX_W = $clog2(DIGIT_COUNT);

    // Divide by ten as a multiply by a scaled reciprocal of ten and a shift.
    // It is exact for any 20-bit dividend.
    localparam int          DIV_STEPS   = 5;
    localparam logic [19:0] RECIP_TEN   = 20'hCCCCD;
    localparam int          RECIP_SHIFT = 23;
    localparam int          PROD_W      = 40;

    // Depth of the queue between converter and output sequencer.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Segment codes and grid select bytes.
    localparam logic [7:0] SEG_DASH   = 8'h02;
    localparam logic [7:0] SEG_BLANK  = 8'h00;
    localparam logic [7:0] GRID_FIRST = 8'h20;
    localparam logic [7:0] GRID_CLOSE = 8'hDF;

    // Segment patterns for hex digits 0 to f.
    localparam logic [7:0] SEG_TABLE [16] = '{
        8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66, 8'hb6, 8'hbe, 8'he4,
        8'hfe, 8'hf6, 8'hfa, 8'h3e, 8'h1a, 8'h7a, 8'h9e, 8'h8e
    };

    // Request modes.
    typedef enum logic [1:0] {
        MODE_ONCE   = 2'd0,
        MODE_SCROLL = 2'd1,
        MODE_ERROR  = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    // One display request.
    typedef struct packed {
        logic [1:0]  mode;
        logic [19:0] value;
    } in_item_t;

    // One grid/segment write.
    typedef struct packed {
        logic [7:0] grid_select;
        logic [7:0] segment_byte;
        logic [2:0] frame_index;
        logic       last;
    } out_item_t;

    typedef logic [DIGIT_COUNT-1:0][7:0] seg_row_t;

    // A converted request as it waits for the output sequencer.
    typedef struct packed {
        logic     scroll;
        logic     close_only;
        seg_row_t segs;
    } job_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

### rtl/core/scsd_front.sv
`timescale 1ns / 1ps

module scsd_front
    import scsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    input  queue_stat_t q_stat,
    output logic        push,
    output job_t        push_job
);

    localparam logic [2:0] STEP_LAST     = 3'(DIV_STEPS - 1);
    localparam logic [2:0] STEP_LAST_ERR = 3'd2;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } fstate_t;

    // Maps a quotient to its segment byte.
    function automatic logic [7:0] seg_code(input logic [19:0] q);
        logic [7:0] s;
        if (q < 20'd16)
            s = SEG_TABLE[q[3:0]];
        else if (q == 20'd16)
            s = SEG_DASH;
        else
            s = SEG_BLANK;
        return s;
    endfunction

    fstate_t          state_reg, state_next;
    logic [19:0]      quot_reg, quot_next;
    logic [2:0]       step_reg, step_next;
    logic             err_reg, err_next;
    logic             scroll_reg, scroll_next;
    logic             zero_reg, zero_next;
    seg_row_t         seg_reg, seg_next;

    logic [PROD_W-1:0] prod;
    logic [19:0]       tenth;
    logic [19:0]       tenth_x10;
    logic [3:0]        digit;

    // One divide by ten per cycle: the quotient moves on, the remainder is a digit.
    assign prod      = PROD_W'(quot_reg) * PROD_W'(RECIP_TEN);
    assign tenth     = 20'(prod[PROD_W-1:RECIP_SHIFT]);
    assign tenth_x10 = (tenth << 3) + (tenth << 1);
    assign digit     = 4'(quot_reg - tenth_x10);

    assign in_stall = (state_reg != F_IDLE);
    assign push     = (state_reg == F_PUSH) && !q_stat.full;

    assign push_job.scroll     = scroll_reg;
    assign push_job.close_only = zero_reg;
    assign push_job.segs       = seg_reg;

    // Next-state logic of the converter.
    always_comb
    begin
        state_next  = state_reg;
        quot_next   = quot_reg;
        step_next   = step_reg;
        err_next    = err_reg;
        scroll_next = scroll_reg;
        zero_next   = zero_reg;
        seg_next    = seg_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid && (in_data.mode != MODE_UNUSED))
                begin
                    quot_next   = in_data.value;
                    step_next   = '0;
                    err_next    = (in_data.mode == MODE_ERROR);
                    scroll_next = (in_data.mode != MODE_ONCE);
                    zero_next   = (in_data.value == 20'd0);
                    seg_next[5] = SEG_BLANK;
                    seg_next[2] = SEG_DASH;
                    state_next  = (in_data.value == 20'd0) ? F_PUSH : F_DIV;
                end
            end
            F_DIV:
            begin
                quot_next = tenth;
                step_next = step_reg + 3'd1;
                if (err_reg && (step_reg == STEP_LAST_ERR))
                begin
                    // Error format puts the hundreds left of the dash and the
                    // thousands and up left of the hundreds.
                    seg_next[3] = seg_code(20'(digit));
                    seg_next[4] = seg_code(tenth);
                    state_next  = F_PUSH;
                end
                else
                begin
                    seg_next[step_reg] = seg_code(20'(digit));
                    if (step_reg == STEP_LAST)
                    begin
                        // What is left after five divisions is the top digit.
                        seg_next[5] = seg_code(tenth);
                        state_next  = F_PUSH;
                    end
                end
            end
            F_PUSH:
            begin
                if (!q_stat.full)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    // Working registers of the conversion.
    always_ff @(posedge clk)
    begin
        quot_reg   <= quot_next;
        step_reg   <= step_next;
        err_reg    <= err_next;
        scroll_reg <= scroll_next;
        zero_reg   <= zero_next;
        seg_reg    <= seg_next;
    end

endmodule

### rtl/core/scsd_queue.sv
`timescale 1ns / 1ps

module scsd_queue
    import scsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  job_t        push_job,
    input  logic        pop,
    output job_t        pop_job,
    output queue_stat_t q_stat
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_job      = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

### rtl/core/scsd_back.sv
`timescale 1ns / 1ps

module scsd_back
    import scsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        dot_mode,
    input  queue_stat_t q_stat,
    input  job_t        pop_job,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data
);

    localparam logic [DIGIT_IDX_W-1:0] DIGIT_LAST = DIGIT_IDX_W'(DIGIT_COUNT - 1);
    localparam logic [2:0]             FRAME_LAST = 3'(DIGIT_COUNT - 1);

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_CLOSE
    } bstate_t;

    // Clock format lights the dots of digits 4 and 2 by adding one.
    function automatic seg_row_t add_dots(input seg_row_t d, input logic dot);
        seg_row_t r;
        r = d;
        if (dot)
        begin
            r[4] = d[4] + 8'd1;
            r[2] = d[2] + 8'd1;
        end
        return r;
    endfunction

    bstate_t                state_reg;
    seg_row_t               d_reg;
    logic [DIGIT_IDX_W-1:0] digit_reg;
    logic [2:0]             frame_reg;
    logic                   scroll_reg;
    logic                   out_valid_reg;
    out_item_t              out_data_reg;

    logic     adv;
    seg_row_t shifted;

    // The output register takes a new write when empty or being drained.
    assign adv       = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == B_IDLE) && !q_stat.empty;
    assign shifted   = {d_reg[DIGIT_COUNT-2:0], SEG_BLANK};
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Output sequencer: six writes per frame, then the closing write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            d_reg         <= '0;
            digit_reg     <= '0;
            frame_reg     <= '0;
            scroll_reg    <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (adv)
                        out_valid_reg <= 1'b0;
                    if (!q_stat.empty)
                    begin
                        d_reg      <= add_dots(pop_job.segs, dot_mode);
                        scroll_reg <= pop_job.scroll;
                        digit_reg  <= '0;
                        frame_reg  <= '0;
                        state_reg  <= pop_job.close_only ? B_CLOSE : B_RUN;
                    end
                end
                B_RUN:
                begin
                    if (adv)
                    begin
                        out_valid_reg             <= 1'b1;
                        out_data_reg.grid_select  <= GRID_FIRST >> digit_reg;
                        out_data_reg.segment_byte <= d_reg[digit_reg];
                        out_data_reg.frame_index  <= frame_reg;
                        out_data_reg.last         <= 1'b0;
                        if (digit_reg == DIGIT_LAST)
                        begin
                            digit_reg <= '0;
                            if (scroll_reg && (frame_reg != FRAME_LAST))
                            begin
                                frame_reg <= frame_reg + 3'd1;
                                d_reg     <= add_dots(shifted, dot_mode);
                            end
                            else
                            begin
                                state_reg <= B_CLOSE;
                            end
                        end
                        else
                        begin
                            digit_reg <= digit_reg + 1'b1;
                        end
                    end
                end
                B_CLOSE:
                begin
                    if (adv)
                    begin
                        out_valid_reg             <= 1'b1;
                        out_data_reg.grid_select  <= GRID_CLOSE;
                        out_data_reg.segment_byte <= SEG_BLANK;
                        out_data_reg.frame_index  <= '0;
                        out_data_reg.last         <= 1'b1;
                        state_reg                 <= B_IDLE;
                    end
                end
                default:
                begin
                    if (adv)
                        out_valid_reg <= 1'b0;
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/scrolling_seven_segment_number_display_core.sv
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  in_data   (mode, value)
// write     out        out_valid/out_stall  out_data  (grid, segments, frame, last)
// config    in         cfg_valid/cfg_ready  cfg_data  (dot_mode)
//
// A scroll request occupies the output sequencer for one load, 36 digit writes and
// one closing write; show once for a load, six digit writes and the closing write,
// and a zero value for a load and the closing write. Conversion divides by ten once per
// cycle with a reciprocal multiply, five divisions per request (three in error format,
// none for zero), and overlaps the previous request's output through a two-entry queue.
// Reset clears the dot mode, the queue and both state machines.
// out_stall holds the output register; in_stall is high while a request converts
// or waits for queue space.
`timescale 1ns / 1ps

module scrolling_seven_segment_number_display_core
    import scsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    logic        dot_mode_reg;
    logic        push;
    logic        pop;
    job_t        push_job;
    job_t        pop_job;
    queue_stat_t q_stat;

    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dot_mode_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            dot_mode_reg <= cfg_data;
    end

    scsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    scsd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    scsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .dot_mode  (dot_mode_reg),
        .q_stat    (q_stat),
        .pop_job   (pop_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // The converter never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_stat.full)
        else $error("queue overflow");

    // The sequencer never takes from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_stat.empty)
        else $error("queue underflow");

    // Digit writes select exactly one grid line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.last) |-> $onehot(out_data.grid_select))
        else $error("digit write without one-hot grid select");

endmodule
